// File: hdl/qde_pkg.sv
// ----------------------------------------------------------------------------
// qde_pkg
// Shared types and constants for the quantile digest engine.
// ----------------------------------------------------------------------------
package qde_pkg;

  // storage sizes
  localparam int BUF_DEPTH = 64;
  localparam int CEN_DEPTH = 64;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int CEN_AW    = $clog2(CEN_DEPTH);
  localparam int BUF_CW    = $clog2(BUF_DEPTH + 1);
  localparam int CEN_CW    = $clog2(CEN_DEPTH + 1);

  // field widths
  localparam int SMP_W  = 32;
  localparam int MEAN_W = 40;
  localparam int WGT_W  = 32;
  localparam int Q_W    = 17;
  localparam int COMP_W = 7;
  localparam int FRAC_W = MEAN_W - SMP_W;

  // arithmetic unit sizes: sum of two mean*weight products
  localparam int ACC_W  = MEAN_W + WGT_W + 1;
  localparam int DIV_W  = WGT_W + 1;
  localparam int STEP_W = $clog2(ACC_W + 1);

  localparam logic [COMP_W-1:0] COMP_RESET = COMP_W'(100);
  localparam logic [Q_W-1:0]    Q_ONE      = Q_W'(65536);

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_FLUSH = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_CLEAR = 2'd3
  } qde_req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } qde_status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_FOLD_INIT,
    S_FETCH,
    S_PICK,
    S_FCHK,
    S_MUL1,
    S_MUL1_W,
    S_MUL2,
    S_MUL2_W,
    S_DIV,
    S_DIV_W,
    S_FEND,
    S_QINIT,
    S_QCHK,
    S_RESP
  } qde_state_t;

  // commands to the shared arithmetic unit
  typedef struct packed {
    logic mul_start;  // acc (+)= opa * opb, one multiplier bit a cycle
    logic mul_acc;    // keep the accumulator instead of clearing it
    logic div_start;  // acc = acc / divisor, one quotient bit a cycle
  } qde_mac_cmd_t;

endpackage

// File: hdl/quantile_digest_engine_core.sv
// ----------------------------------------------------------------------------
// quantile_digest_engine_core
// Merging quantile sketch: sorted sample buffer plus centroid table.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: tuser = kind (add, flush, query, clear),
//   tdata = sample and quantile. m_axis returns exactly one response per
//   request: tuser = status and answer-valid flag, tdata = Q32.8 answer.
//   cfg_wen/cfg_wdata write the compression factor; write only when idle.
// Operation:
//   The block takes one request at a time; s_axis_tready is high only while
//   idle. An add inserts into the sorted buffer with one read/write pair per
//   shifted entry, moving each larger entry up one place. A flush walks
//   buffer and table once, and each join of two entries runs the shared
//   multiply/divide unit. A query walks the merged view until it hits the
//   target. Clear and error requests go straight to the response stage.
// Reset clears all counts (digest empty) and sets compression to 100.
// When m_axis stalls the response holds in the output register; the next
// request is still accepted and runs up to its response stage.
// ----------------------------------------------------------------------------
module quantile_digest_engine_core import qde_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_wen,
  input  logic [COMP_W-1:0] cfg_wdata,      // compression
  // request stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [55:0]       s_axis_tdata,   // [31:0] sample, [48:32] quantile
  input  logic [1:0]        s_axis_tuser,   // [1:0] req_type
  // response stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [39:0]       m_axis_tdata,   // [39:0] value
  output logic [2:0]        m_axis_tuser    // [1:0] status, [2] answer_valid
);

  qde_state_t st, st_next;

  // digest state
  logic [BUF_CW-1:0]  buf_cnt;
  logic [CEN_CW-1:0]  cen_cnt;
  logic [WGT_W-1:0]   total;
  logic [COMP_W-1:0]  comp;
  logic               bank;

  // latched request
  qde_req_t           req;
  logic [SMP_W-1:0]   smp;
  logic [Q_W-1:0]     qv;

  // walk registers
  logic [BUF_CW-1:0]  ins_j;
  logic [BUF_CW-1:0]  bi;
  logic [CEN_CW-1:0]  ci;
  logic [CEN_AW-1:0]  out_idx;
  logic               first;
  logic [MEAN_W-1:0]  cm;
  logic [WGT_W-1:0]   cw;
  logic [MEAN_W-1:0]  ev;
  logic [WGT_W-1:0]   ew;
  logic [WGT_W+1:0]   limit;
  logic [WGT_W-1:0]   cum;
  logic [Q_W+WGT_W-1:0] target;
  logic [MEAN_W-1:0]  last_v;

  // pending response and output register
  qde_status_t        r_status;
  logic [MEAN_W-1:0]  r_value;
  logic               r_avalid;
  logic               o_valid;
  qde_status_t        o_status;
  logic [MEAN_W-1:0]  o_value;
  logic               o_avalid;

  // memories
  logic [SMP_W-1:0]         buf_mem [BUF_DEPTH];
  logic [MEAN_W+WGT_W-1:0]  cen_mem [2*CEN_DEPTH];
  logic [SMP_W-1:0]         buf_rdata;
  logic [MEAN_W+WGT_W-1:0]  cen_rdata;
  logic                     buf_we;
  logic [BUF_AW-1:0]        buf_waddr, buf_raddr;
  logic [SMP_W-1:0]         buf_wdata;
  logic                     cen_we;

  // shared arithmetic unit
  qde_mac_cmd_t       mac_cmd;
  logic [MEAN_W-1:0]  mac_a;
  logic [WGT_W-1:0]   mac_b;
  logic               mac_busy;
  logic [MEAN_W-1:0]  mac_q;

  // request fields
  qde_req_t           in_req;
  logic [SMP_W-1:0]   in_smp;
  logic [Q_W-1:0]     in_q;
  logic               in_acc;

  // walk decisions
  logic               b_av, c_av, take_b, shift_up, join_ok, q_hit;
  logic [MEAN_W-1:0]  bv, cv;
  logic [WGT_W:0]     jw;
  logic [WGT_W:0]     cum_w;
  logic               is_fold;

  assign in_req = qde_req_t'(s_axis_tuser);
  assign in_smp = s_axis_tdata[SMP_W-1:0];
  assign in_q   = s_axis_tdata[SMP_W+Q_W-1:SMP_W];
  assign s_axis_tready = (st == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  assign is_fold  = (req != REQ_QUERY);
  assign b_av     = (bi < buf_cnt);
  assign c_av     = (ci < cen_cnt);
  assign bv       = {buf_rdata, {FRAC_W{1'b0}}};
  assign cv       = cen_rdata[MEAN_W+WGT_W-1:WGT_W];
  // fold: buffer first on equal means; query: table first
  assign take_b   = b_av && (!c_av || (is_fold ? (bv <= cv) : (bv < cv)));
  assign shift_up = (buf_rdata > smp);
  assign jw       = {1'b0, cw} + {1'b0, ew};
  assign join_ok  = ((jw * comp) <= {{(MEAN_W-WGT_W-2){1'b0}}, limit}) ||
                    (out_idx == CEN_AW'(CEN_DEPTH - 1));
  assign cum_w    = {1'b0, cum} + {1'b0, ew};
  assign q_hit    = ({cum_w, 16'b0} >= target);

  // buffer memory ports
  always_comb begin
    buf_we    = 1'b0;
    buf_waddr = ins_j[BUF_AW-1:0];
    buf_wdata = smp;
    buf_raddr = bi[BUF_AW-1:0];
    case (st)
      S_INS_RD: begin
        buf_raddr = BUF_AW'(ins_j - 1'b1);
        buf_we    = (ins_j == '0);
      end
      S_INS_WR: begin
        buf_we    = 1'b1;
        buf_wdata = shift_up ? buf_rdata : smp;
      end
      default: ;
    endcase
  end

  assign cen_we = (st == S_FEND) || ((st == S_FCHK) && !first && !join_ok);

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= buf_wdata;
    end
    buf_rdata <= buf_mem[buf_raddr];
  end

  always_ff @(posedge clk) begin
    if (cen_we) begin
      cen_mem[{~bank, out_idx}] <= {cm, cw};
    end
    cen_rdata <= cen_mem[{bank, ci[CEN_AW-1:0]}];
  end

  // arithmetic unit commands
  always_comb begin
    mac_cmd   = '0;
    mac_a     = cm;
    mac_b     = cw;
    case (st)
      S_MUL1: mac_cmd.mul_start = 1'b1;
      S_MUL2: begin
        mac_cmd.mul_start = 1'b1;
        mac_cmd.mul_acc   = 1'b1;
        mac_a             = ev;
        mac_b             = ew;
      end
      S_DIV:  mac_cmd.div_start = 1'b1;
      default: ;
    endcase
  end

  qde_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .cmd     (mac_cmd),
    .opa     (mac_a),
    .opb     (mac_b),
    .divisor (jw),
    .busy    (mac_busy),
    .quo     (mac_q)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // next state
  always_comb begin
    st_next = st;
    case (st)
      S_IDLE: begin
        if (in_acc) begin
          case (in_req)
            REQ_ADD: begin
              if (total == '1)                          st_next = S_RESP;
              else if (buf_cnt == BUF_CW'(BUF_DEPTH))   st_next = S_FOLD_INIT;
              else                                      st_next = S_INS_RD;
            end
            REQ_FLUSH: st_next = S_FOLD_INIT;
            REQ_QUERY: begin
              if (in_q > Q_ONE || total == '0) st_next = S_RESP;
              else                            st_next = S_QINIT;
            end
            default: st_next = S_RESP;
          endcase
        end
      end
      S_INS_RD:    st_next = (ins_j == '0) ? S_RESP : S_INS_WR;
      S_INS_WR:    st_next = shift_up ? S_INS_RD : S_RESP;
      S_FOLD_INIT: st_next = (buf_cnt == '0 && cen_cnt == '0) ? S_RESP : S_FETCH;
      S_FETCH: begin
        if (!b_av && !c_av) st_next = is_fold ? S_FEND : S_RESP;
        else                st_next = S_PICK;
      end
      S_PICK:      st_next = is_fold ? S_FCHK : S_QCHK;
      S_FCHK:      st_next = (!first && join_ok) ? S_MUL1 : S_FETCH;
      S_MUL1:      st_next = S_MUL1_W;
      S_MUL1_W:    st_next = mac_busy ? S_MUL1_W : S_MUL2;
      S_MUL2:      st_next = S_MUL2_W;
      S_MUL2_W:    st_next = mac_busy ? S_MUL2_W : S_DIV;
      S_DIV:       st_next = S_DIV_W;
      S_DIV_W:     st_next = mac_busy ? S_DIV_W : S_FETCH;
      S_FEND:      st_next = (req == REQ_ADD) ? S_INS_RD : S_RESP;
      S_QINIT:     st_next = S_FETCH;
      S_QCHK:      st_next = q_hit ? S_RESP : S_FETCH;
      S_RESP:      st_next = (!o_valid || m_axis_tready) ? S_IDLE : S_RESP;
      default:     st_next = S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= '0;
      cen_cnt <= '0;
      total   <= '0;
      comp    <= COMP_RESET;
      bank    <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        comp <= cfg_wdata;
      end
      // drop a taken response unless the next one loads this cycle
      if (o_valid && m_axis_tready && (st != S_RESP)) begin
        o_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (in_acc) begin
            req      <= in_req;
            smp      <= in_smp;
            qv       <= in_q;
            ins_j    <= buf_cnt;
            r_value  <= '0;
            r_avalid <= 1'b0;
            case (in_req)
              REQ_ADD: begin
                r_status <= (total == '1) ? ST_FULL : ST_OK;
              end
              REQ_QUERY: begin
                if (in_q > Q_ONE)      r_status <= ST_RANGE;
                else if (total == '0)  r_status <= ST_EMPTY;
                else                   r_status <= ST_OK;
              end
              REQ_CLEAR: begin
                r_status <= ST_OK;
                buf_cnt  <= '0;
                cen_cnt  <= '0;
                total    <= '0;
              end
              default: r_status <= ST_OK;
            endcase
          end
        end
        S_INS_RD: begin
          if (ins_j == '0) begin
            buf_cnt <= buf_cnt + 1'b1;
            total   <= total + 1'b1;
          end
        end
        S_INS_WR: begin
          if (shift_up) begin
            ins_j <= ins_j - 1'b1;
          end else begin
            buf_cnt <= buf_cnt + 1'b1;
            total   <= total + 1'b1;
          end
        end
        S_FOLD_INIT: begin
          bi      <= '0;
          ci      <= '0;
          out_idx <= '0;
          first   <= 1'b1;
          if ({total, 2'b00} < {{(WGT_W+2-COMP_W){1'b0}}, comp})
            limit <= {{(WGT_W+2-COMP_W){1'b0}}, comp};
          else
            limit <= {total, 2'b00};
        end
        S_FETCH: begin
          if (!b_av && !c_av && !is_fold) begin
            r_value  <= last_v;
            r_avalid <= 1'b1;
          end
        end
        S_PICK: begin
          if (take_b) begin
            ev <= bv;
            ew <= WGT_W'(1);
            bi <= bi + 1'b1;
          end else begin
            ev <= cv;
            ew <= cen_rdata[WGT_W-1:0];
            ci <= ci + 1'b1;
          end
        end
        S_FCHK: begin
          if (first) begin
            cm    <= ev;
            cw    <= ew;
            first <= 1'b0;
          end else if (!join_ok) begin
            out_idx <= out_idx + 1'b1;
            cm      <= ev;
            cw      <= ew;
          end
        end
        S_DIV_W: begin
          if (!mac_busy) begin
            cm <= mac_q;
            cw <= jw[WGT_W-1:0];
          end
        end
        S_FEND: begin
          cen_cnt <= {1'b0, out_idx} + 1'b1;
          buf_cnt <= '0;
          bank    <= ~bank;
          ins_j   <= '0;
        end
        S_QINIT: begin
          target <= qv * total;
          cum    <= '0;
          last_v <= '0;
          bi     <= '0;
          ci     <= '0;
        end
        S_QCHK: begin
          if (q_hit) begin
            r_value  <= ev;
            r_avalid <= 1'b1;
          end else begin
            cum    <= cum_w[WGT_W-1:0];
            last_v <= ev;
          end
        end
        S_RESP: begin
          if (!o_valid || m_axis_tready) begin
            o_valid  <= 1'b1;
            o_status <= r_status;
            o_value  <= r_value;
            o_avalid <= r_avalid;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_value;
  assign m_axis_tuser  = {o_avalid, o_status};

  // checks
  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    buf_cnt <= BUF_CW'(BUF_DEPTH))
    else $error("buffer count past depth");

  a_cen_bound: assert property (@(posedge clk) disable iff (rst)
    cen_cnt <= CEN_CW'(CEN_DEPTH))
    else $error("centroid count past depth");

  a_answer_ok: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_avalid |-> o_status == ST_OK)
    else $error("answer flagged with error status");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_avalid |-> o_value == '0)
    else $error("nonzero value without answer");

  a_mac_wait: assert property (@(posedge clk) disable iff (rst)
    mac_busy |-> (st == S_MUL1_W || st == S_MUL2_W || st == S_DIV_W))
    else $error("sequencer left arithmetic unit running");

endmodule

// File: hdl/qde_mac.sv
// ----------------------------------------------------------------------------
// qde_mac
// Shared shift-add multiply-accumulate and restoring divide unit.
// ----------------------------------------------------------------------------
module qde_mac import qde_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  qde_mac_cmd_t      cmd,
  input  logic [MEAN_W-1:0] opa,
  input  logic [WGT_W-1:0]  opb,
  input  logic [DIV_W-1:0]  divisor,
  output logic              busy,
  output logic [MEAN_W-1:0] quo
);

  logic [ACC_W-1:0]   acc;
  logic [ACC_W-2:0]   ma;
  logic [WGT_W-1:0]   mb;
  logic [DIV_W-1:0]   dv;
  logic [DIV_W:0]     rem;
  logic [STEP_W-1:0]  cnt;
  logic               is_div;

  logic [DIV_W:0]     rem_sh;
  logic               ge;

  // one restoring divide step
  assign rem_sh = {rem[DIV_W-1:0], acc[ACC_W-1]};
  assign ge     = (rem_sh >= {1'b0, dv});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      is_div <= 1'b0;
    end else if (cmd.mul_start) begin
      ma     <= {{(ACC_W-1-MEAN_W){1'b0}}, opa};
      mb     <= opb;
      if (!cmd.mul_acc) begin
        acc <= '0;
      end
      cnt    <= STEP_W'(WGT_W);
      is_div <= 1'b0;
    end else if (cmd.div_start) begin
      dv     <= divisor;
      rem    <= '0;
      cnt    <= STEP_W'(ACC_W);
      is_div <= 1'b1;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
      if (is_div) begin
        rem <= ge ? (rem_sh - {1'b0, dv}) : rem_sh;
        acc <= {acc[ACC_W-2:0], ge};
      end else begin
        if (mb[0]) begin
          acc <= acc + {1'b0, ma};
        end
        ma <= {ma[ACC_W-3:0], 1'b0};
        mb <= {1'b0, mb[WGT_W-1:1]};
      end
    end
  end

  assign busy = (cnt != '0);
  assign quo  = acc[MEAN_W-1:0];

endmodule

// File: tb/sv/qde_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qde_checker
// Watches the request, response and config ports of the quantile digest
// engine, keeps its own copy of the digest state, predicts one response per
// accepted request and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module qde_checker import qde_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [COMP_W-1:0] cfg_wdata,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [55:0]       s_axis_tdata,   // [31:0] sample, [48:32] quantile
  input  logic [1:0]        s_axis_tuser,   // [1:0] req_type
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [39:0]       m_axis_tdata,   // [39:0] value
  input  logic [2:0]        m_axis_tuser,   // [1:0] status, [2] answer_valid
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    qde_status_t       status;
    logic [MEAN_W-1:0] value;
    logic              answer_valid;
  } resp_t;

  // digest shadow state
  logic [SMP_W-1:0]  raw_buf [BUF_DEPTH];
  int unsigned       raw_cnt;
  logic [MEAN_W-1:0] cen_mean [CEN_DEPTH];
  logic [WGT_W-1:0]  cen_wgt [CEN_DEPTH];
  int unsigned       cen_cnt;
  logic [31:0]       sample_total;
  logic [COMP_W-1:0] comp;

  // merged view scratch
  logic [MEAN_W-1:0] view_mean [BUF_DEPTH + CEN_DEPTH];
  logic [63:0]       view_wgt [BUF_DEPTH + CEN_DEPTH];

  resp_t responses_due[$];
  int    mismatch_cnt;

  assign pending = responses_due.size();

  // stable insertion sort by mean
  task automatic sort_view(input int n);
    logic [MEAN_W-1:0] m;
    logic [63:0]       w;
    int                j;
    for (int i = 1; i < n; i++) begin
      m = view_mean[i];
      w = view_wgt[i];
      j = i;
      while (j > 0 && view_mean[j-1] > m) begin
        view_mean[j] = view_mean[j-1];
        view_wgt[j]  = view_wgt[j-1];
        j--;
      end
      view_mean[j] = m;
      view_wgt[j]  = w;
    end
  endtask

  // fold buffered samples into the centroid table
  task automatic fold_digest();
    int          n;
    int unsigned emitted;
    logic [63:0] sum, cap, cw, w;
    logic [MEAN_W-1:0] cm;
    logic [127:0] num;
    n = 0;
    emitted = 0;
    sum = 0;
    if (raw_cnt == 0 && cen_cnt == 0) return;
    for (int i = 0; i < raw_cnt; i++) begin
      view_mean[n] = {raw_buf[i], 8'h00};
      view_wgt[n]  = 1;
      n++;
    end
    for (int i = 0; i < cen_cnt; i++) begin
      view_mean[n] = cen_mean[i];
      view_wgt[n]  = cen_wgt[i];
      n++;
    end
    raw_cnt = 0;
    sort_view(n);
    for (int i = 0; i < n; i++) sum += view_wgt[i];
    cap = 4 * sum;
    if (cap < comp) cap = comp;
    cm = view_mean[0];
    cw = view_wgt[0];
    for (int i = 1; i < n; i++) begin
      w = view_wgt[i];
      if ((cw + w) * comp <= cap || emitted >= CEN_DEPTH - 1) begin
        num = 128'(cm) * 128'(cw) + 128'(view_mean[i]) * 128'(w);
        cm  = MEAN_W'(num / 128'(cw + w));
        cw  = cw + w;
      end else begin
        cen_mean[emitted] = cm;
        cen_wgt[emitted]  = cw[31:0];
        emitted++;
        cm = view_mean[i];
        cw = w;
      end
    end
    cen_mean[emitted] = cm;
    cen_wgt[emitted]  = cw[31:0];
    cen_cnt = emitted + 1;
  endtask

  task automatic predict_response(input qde_req_t kind, input logic [SMP_W-1:0] smp,
                                  input logic [Q_W-1:0] q, output resp_t r);
    int          n;
    logic [63:0] target, cum;
    r = '{status: ST_OK, value: '0, answer_valid: 1'b0};
    case (kind)
      REQ_ADD: begin
        if (sample_total == 32'hFFFF_FFFF) begin
          r.status = ST_FULL;
        end else begin
          if (raw_cnt >= BUF_DEPTH) fold_digest();
          raw_buf[raw_cnt] = smp;
          raw_cnt++;
          sample_total++;
        end
      end
      REQ_FLUSH: fold_digest();
      REQ_QUERY: begin
        if (q > Q_ONE) begin
          r.status = ST_RANGE;
        end else if (sample_total == 0) begin
          r.status = ST_EMPTY;
        end else begin
          n = 0;
          for (int i = 0; i < cen_cnt; i++) begin
            view_mean[n] = cen_mean[i];
            view_wgt[n]  = cen_wgt[i];
            n++;
          end
          for (int i = 0; i < raw_cnt; i++) begin
            view_mean[n] = {raw_buf[i], 8'h00};
            view_wgt[n]  = 1;
            n++;
          end
          sort_view(n);
          if (n == 0) begin
            r.status = ST_EMPTY;
          end else begin
            target = 64'(q) * 64'(sample_total);
            cum = 0;
            r.value = view_mean[n-1];
            for (int i = 0; i < n; i++) begin
              if ((cum + view_wgt[i]) * 65536 >= target) begin
                r.value = view_mean[i];
                break;
              end
              cum += view_wgt[i];
            end
            r.answer_valid = 1'b1;
          end
        end
      end
      default: begin
        raw_cnt = 0;
        cen_cnt = 0;
        sample_total = 0;
      end
    endcase
  endtask

  // inputs settle at the rising edge, so the falling edge sees the values
  // that the next rising edge will use
  always @(negedge clk) begin
    resp_t r, exp_r;
    if (rst) begin
      raw_cnt = 0;
      cen_cnt = 0;
      sample_total = 0;
      comp = COMP_RESET;
      responses_due.delete();
      fail_count = 0;
      mismatch_cnt = 0;
    end else begin
      if (cfg_wen) comp = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_response(qde_req_t'(s_axis_tuser), s_axis_tdata[31:0],
                         s_axis_tdata[48:32], r);
        responses_due = {responses_due, r};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (responses_due.size() == 0) begin
          fail_count++;
          if (mismatch_cnt < 10) $display("unexpected response %h/%h", m_axis_tuser,
                                          m_axis_tdata);
          mismatch_cnt++;
        end else begin
          exp_r = responses_due.pop_front();
          if (m_axis_tuser[1:0] !== exp_r.status || m_axis_tuser[2] !== exp_r.answer_valid
              || m_axis_tdata !== exp_r.value) begin
            fail_count++;
            if (mismatch_cnt < 10)
              $display("response mismatch: exp st=%0d av=%0d val=%h got st=%0d av=%0d val=%h",
                       exp_r.status, exp_r.answer_valid, exp_r.value,
                       m_axis_tuser[1:0], m_axis_tuser[2], m_axis_tdata);
            mismatch_cnt++;
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives requests and config writes into the quantile digest engine with
// random gaps and response stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import qde_pkg::*;

  localparam longint CYCLE_LIMIT = 40_000_000;

  logic              clk;
  logic              rst;
  logic              cfg_wen;
  logic [COMP_W-1:0] cfg_wdata;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [55:0]       s_axis_tdata;   // [31:0] sample, [48:32] quantile
  logic [1:0]        s_axis_tuser;   // [1:0] req_type
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [39:0]       m_axis_tdata;   // [39:0] value
  logic [2:0]        m_axis_tuser;   // [1:0] status, [2] answer_valid
  int                fail_count;
  int                pending;

  longint cycles = 0;
  bit     tx_fast, rx_fast;
  bit     rx_done_seen;
  int     rx_stall;

  quantile_digest_engine_core i_dut (.*);
  qde_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL quantile_digest_engine_core");
      $finish;
    end
  end

  // response side: random stall after each taken response
  always @(negedge clk) rx_done_seen = m_axis_tvalid && m_axis_tready;

  always @(posedge clk) begin
    int n;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_stall <= 0;
    end else if (rx_done_seen) begin
      n = rx_fast ? 0 : $urandom_range(0, 18);
      rx_stall <= n;
      m_axis_tready <= (n == 0);
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready <= (rx_stall == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_request(input qde_req_t kind, input logic [31:0] smp,
                              input logic [16:0] q);
    int  gap;
    bit  hit;
    gap = tx_fast ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'd0, q, smp};
    hit = 1'b0;
    while (!hit) begin
      @(negedge clk);
      hit = s_axis_tready;
      @(posedge clk);
    end
  endtask

  // hold off until the digest has answered everything
  task automatic drain_responses();
    @(posedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_compression(input logic [COMP_W-1:0] c);
    cfg_wen   <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 15);
      3:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] pick_quantile();
    case ($urandom_range(0, 9))
      0:       return 17'($urandom_range(0, 131071));
      1:       return Q_ONE;
      2:       return 17'd0;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    logic [COMP_W-1:0] comp_plan [6];
    int pick;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    tx_fast = 1'b0;
    rx_fast = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty digest, range errors, extremes, equal means
    send_request(REQ_QUERY, 32'd0, 17'd0);
    send_request(REQ_QUERY, 32'd0, 17'd65537);
    send_request(REQ_QUERY, 32'hFFFF_FFFF, 17'h1FFFF);
    send_request(REQ_FLUSH, 32'd0, 17'd0);
    send_request(REQ_CLEAR, 32'd0, 17'd0);
    send_request(REQ_ADD, 32'd0, 17'd0);
    send_request(REQ_ADD, 32'hFFFF_FFFF, 17'h1FFFF);
    send_request(REQ_ADD, 32'd5, 17'd0);
    send_request(REQ_ADD, 32'd5, 17'd0);
    send_request(REQ_ADD, 32'd5, 17'd0);
    send_request(REQ_QUERY, 32'd0, 17'd0);
    send_request(REQ_QUERY, 32'd0, Q_ONE);
    send_request(REQ_QUERY, 32'd0, 17'd32768);
    send_request(REQ_FLUSH, 32'd0, 17'd0);
    send_request(REQ_ADD, 32'd5, 17'd0);
    send_request(REQ_QUERY, 32'd0, Q_ONE);
    send_request(REQ_QUERY, 32'd0, 17'd30000);
    send_request(REQ_FLUSH, 32'd0, 17'd0);
    send_request(REQ_QUERY, 32'd0, 17'd50000);
    send_request(REQ_CLEAR, 32'd0, 17'd0);
    send_request(REQ_QUERY, 32'd0, 17'd100);
    drain_responses();

    // random phases, each under its own compression
    comp_plan[0] = 7'd1;
    comp_plan[1] = 7'd126;
    comp_plan[2] = COMP_RESET;
    for (int p = 3; p < 6; p++) comp_plan[p] = 7'($urandom_range(1, 126));
    for (int p = 0; p < 6; p++) begin
      write_compression(comp_plan[p]);
      tx_fast = (p % 3 == 1);
      rx_fast = (p % 3 == 2);
      for (int k = 0; k < 140; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 62)
          send_request(REQ_ADD, pick_sample(), 17'($urandom_range(0, 131071)));
        else if (pick < 90)
          send_request(REQ_QUERY, $urandom, pick_quantile());
        else if (pick < 98)
          send_request(REQ_FLUSH, $urandom, 17'($urandom_range(0, 131071)));
        else
          send_request(REQ_CLEAR, $urandom, 17'($urandom_range(0, 131071)));
      end
      drain_responses();
    end

    tx_fast = 1'b0;
    rx_fast = 1'b0;
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS quantile_digest_engine_core");
    end else begin
      $display("FAIL quantile_digest_engine_core");
    end
    $finish;
  end

endmodule
